@@ hw/rtl/ptb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_pkg - shared types and constants of the palette threshold blitter
// Panel geometry, palette size, request codes, queue entry and gray helper.
// ----------------------------------------------------------------------------
package ptb_pkg;

    // panel and palette geometry
    localparam int FB_WIDTH     = 1024;
    localparam int FB_HEIGHT    = 768;
    localparam int PALETTE_SIZE = 256;

    localparam int ROW_BYTES    = FB_WIDTH / 8;
    localparam int STORE_BYTES  = ROW_BYTES * FB_HEIGHT;
    localparam int VIS_WIDTH    = ROW_BYTES * 8;

    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int PAL_AW       = $clog2(PALETTE_SIZE);
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int FB_ADDR_W    = 17;

    // signed widths of the shifted pixel position
    localparam int XW           = 14;
    localparam int YW           = 13;

    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    // request kinds
    localparam logic REQ_PALETTE = 1'b0;
    localparam logic REQ_PIXEL   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 1'd1;

    // rgb565 gray weighting
    localparam logic [15:0] GRAY_R_MASK  = 16'hF800;
    localparam logic [15:0] GRAY_G_MASK  = 16'h07E0;
    localparam logic [15:0] GRAY_B_MASK  = 16'h001F;
    localparam int          GRAY_R_SHR   = 8;
    localparam int          GRAY_G_SHR   = 2;
    localparam int          GRAY_B_SHL   = 3;
    localparam int          GRAY_BIT     = 9;

    localparam logic [7:0]  PIX_MSB_MASK = 8'h80;

    // classified item between front and queue stage
    typedef struct packed {
        logic              write;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_pos;
        logic              pal_ok;
    } t_front;

    // queue entry handed to the back end
    typedef struct packed {
        logic              write;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_pos;
        logic              pix;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic gray_bit(input logic [15:0] color);
        logic [9:0] r_part;
        logic [9:0] g_part;
        logic [9:0] b_part;
        logic [9:0] gray;
        r_part = 10'((color & GRAY_R_MASK) >> GRAY_R_SHR);
        g_part = 10'((color & GRAY_G_MASK) >> GRAY_G_SHR);
        b_part = 10'((color & GRAY_B_MASK) << GRAY_B_SHL);
        gray   = r_part + g_part + b_part;
        return gray[GRAY_BIT];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ptb_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_in_if - request channel of the blitter
// Palette loads and pixel draws with valid / ready handshake.
// ----------------------------------------------------------------------------
interface ptb_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] palette_index;
    logic [15:0] palette_color;
    logic [9:0] line_x;
    logic [9:0] line_y;
    logic [9:0] pixel_offset;
    logic [7:0] pixel_value;
    logic [7:0] transparent_index;
    logic [7:0] background_index;
    logic       uses_transparency;
    logic       restore_background;

    modport source (
        output valid, req_type, palette_index, palette_color, line_x, line_y,
               pixel_offset, pixel_value, transparent_index, background_index,
               uses_transparency, restore_background,
        input  ready
    );

    modport sink (
        input  valid, req_type, palette_index, palette_color, line_x, line_y,
               pixel_offset, pixel_value, transparent_index, background_index,
               uses_transparency, restore_background,
        output ready
    );
endinterface
`default_nettype wire

@@ hw/rtl/ptb_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_out_if - result channel of the blitter
// One framebuffer write report per request, valid / ready handshake.
// ----------------------------------------------------------------------------
interface ptb_out_if;
    logic        valid;
    logic        ready;
    logic        write_done;
    logic [16:0] fb_address;
    logic [7:0]  fb_byte;

    modport source (
        output valid, write_done, fb_address, fb_byte,
        input  ready
    );

    modport sink (
        input  valid, write_done, fb_address, fb_byte,
        output ready
    );
endinterface
`default_nettype wire

@@ hw/rtl/ptb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_ram - generic simple dual port ram
// One write port, one read port with registered data (read returns old data).
// ----------------------------------------------------------------------------
module ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ hw/rtl/ptb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_front - request intake and classification
// Loads the palette, maps pixels, clips them and forms byte address and bit.
// ----------------------------------------------------------------------------
module ptb_front import ptb_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    ptb_in_if.sink                       i_req,
    input  wire logic signed [CFG_W-1:0] i_offset_x,
    input  wire logic signed [CFG_W-1:0] i_offset_y,
    input  wire logic                    i_clearing,
    input  wire t_q_stat                 i_q_stat,
    output logic                         o_push,
    output t_cmd                         o_push_cmd
);
    logic                   accept;
    logic                   is_pix;
    logic                   is_transp;
    logic [7:0]             eff_index;
    logic                   skip;
    logic                   seg_clip;
    logic signed [XW-1:0]   x_pos;
    logic signed [YW-1:0]   y_pos;
    logic                   on_panel;
    logic [31:0]            lin_addr;
    logic                   addr_ok;
    logic                   pal_we;
    logic                   pal_rdata;
    t_front                 n_f1;
    t_front                 r_f1;
    logic                   r_f1_valid;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = !i_clearing && (!r_f1_valid || !i_q_stat.full);

    always_comb begin
        is_pix    = (i_req.req_type == REQ_PIXEL);
        is_transp = (i_req.pixel_value == i_req.transparent_index);
        eff_index = (i_req.restore_background && is_transp) ? i_req.background_index
                                                            : i_req.pixel_value;
        skip      = !i_req.restore_background && i_req.uses_transparency && is_transp;
        seg_clip  = (XW'(i_req.pixel_offset) >= XW'(FB_WIDTH));

        // canvas position shifted by the centering offsets
        x_pos = signed'(XW'(i_req.line_x)) + signed'(XW'(i_req.pixel_offset))
              + XW'(i_offset_x);
        y_pos = signed'(YW'(i_req.line_y)) + YW'(i_offset_y);

        on_panel = !x_pos[XW-1] && (x_pos < XW'(VIS_WIDTH))
                && !y_pos[YW-1] && (y_pos < YW'(FB_HEIGHT));

        lin_addr = 32'(y_pos[YW-2:0]) * 32'(ROW_BYTES) + 32'(x_pos[XW-2:3]);
        addr_ok  = (lin_addr < 32'(STORE_BYTES));

        n_f1.write   = is_pix && !seg_clip && !skip && on_panel && addr_ok;
        n_f1.addr    = lin_addr[ADDR_W-1:0];
        n_f1.bit_pos = x_pos[2:0];
        n_f1.pal_ok  = ({1'b0, eff_index} < 9'(PALETTE_SIZE));

        pal_we = accept && !is_pix && ({1'b0, i_req.palette_index} < 9'(PALETTE_SIZE));
    end

    // one threshold bit per palette entry
    ptb_ram #(
        .WIDTH (1),
        .DEPTH (PALETTE_SIZE)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_req.palette_index[PAL_AW-1:0]),
        .i_wdata (gray_bit(i_req.palette_color)),
        .i_re    (accept && is_pix),
        .i_raddr (eff_index[PAL_AW-1:0]),
        .o_rdata (pal_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (accept) begin
            r_f1_valid <= 1'b1;
        end else if (o_push) begin
            r_f1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1 <= n_f1;
        end
    end

    always_comb begin
        o_push             = r_f1_valid && !i_q_stat.full;
        o_push_cmd.write   = r_f1.write;
        o_push_cmd.addr    = r_f1.addr;
        o_push_cmd.bit_pos = r_f1.bit_pos;
        o_push_cmd.pix     = r_f1.pal_ok && pal_rdata;
    end
endmodule
`default_nettype wire

@@ hw/rtl/ptb_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_queue - short command queue between front and back
// Flop based fifo, head entry shown while not empty.
// ----------------------------------------------------------------------------
module ptb_queue import ptb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_push_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_stat   o_stat
);
    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
endmodule
`default_nettype wire

@@ hw/rtl/ptb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_back - framebuffer read-modify-write engine
// Clears the store after reset, merges pixels into bytes, drives results.
// ----------------------------------------------------------------------------
module ptb_back import ptb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    output logic         o_clearing,
    ptb_out_if.source    o_res
);
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_b1_valid;
    t_cmd              r_b1;
    logic              r_out_valid;
    logic              r_out_done;
    logic [ADDR_W-1:0] r_out_addr;
    logic [7:0]        r_out_byte;
    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [7:0]        r_fwd_data;

    logic              slot_free;
    logic              b1_adv;
    logic [7:0]        fb_rdata;
    logic [7:0]        old_byte;
    logic [7:0]        mask;
    logic [7:0]        new_byte;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;

    always_comb begin
        slot_free = !r_out_valid || o_res.ready;
        b1_adv    = r_b1_valid && slot_free;
        o_pop     = !r_clearing && !i_q_stat.empty && (!r_b1_valid || slot_free);

        // a write at the edge of this byte's read is not yet in the ram data
        old_byte  = (r_fwd_valid && (r_fwd_addr == r_b1.addr)) ? r_fwd_data : fb_rdata;
        mask      = PIX_MSB_MASK >> r_b1.bit_pos;
        new_byte  = r_b1.pix ? (old_byte | mask) : (old_byte & ~mask);

        ram_we    = r_clearing || (b1_adv && r_b1.write);
        ram_waddr = r_clearing ? r_clr_addr : r_b1.addr;
        ram_wdata = r_clearing ? 8'h00 : new_byte;
    end

    ptb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (o_pop && i_head.write),
        .i_raddr (i_head.addr),
        .o_rdata (fb_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (o_pop) begin
                r_b1_valid <= 1'b1;
            end else if (b1_adv) begin
                r_b1_valid <= 1'b0;
            end
            if (b1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1 <= i_head;
        end
        if (ram_we) begin
            r_fwd_addr <= ram_waddr;
            r_fwd_data <= ram_wdata;
        end
        if (b1_adv) begin
            r_out_done <= r_b1.write;
            r_out_addr <= r_b1.write ? r_b1.addr : '0;
            r_out_byte <= r_b1.write ? new_byte : 8'h00;
        end
    end

    assign o_clearing       = r_clearing;
    assign o_res.valid      = r_out_valid;
    assign o_res.write_done = r_out_done;
    assign o_res.fb_address = FB_ADDR_W'(r_out_addr);
    assign o_res.fb_byte    = r_out_byte;
endmodule
`default_nettype wire

@@ hw/rtl/palette_threshold_1bpp_blitter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_threshold_1bpp_blitter - indexed color to 1 bpp framebuffer blit
// Thresholds an rgb565 palette to one bit per entry and merges pixels into a
// packed 1 bpp framebuffer, reporting for every request the byte it wrote, if any.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              carries
//  i_req     in   valid / ready          palette load or pixel draw request
//  o_res     out  valid / ready          write flag, byte address, new byte
//  cfg       in   i_cfg_we (no ready)    centering offsets x and y
//
//  one transfer per cycle in both directions when the sink keeps ready high
//  a request passes the front, queue, back and output registers in turn
//  front: intake + palette ram read; back: frame ram read, merge, write back
//  after reset the STORE_BYTES byte frame store (98304 at 1024 x 768) is zeroed
//  one byte a cycle and i_req.ready stays low until that is done
//  a stalled result holds in the output register; the queue absorbs the front
// ----------------------------------------------------------------------------
module palette_threshold_1bpp_blitter import ptb_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ptb_in_if.sink                    i_req,
    ptb_out_if.source                 o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);
    // centering offsets
    logic signed [CFG_W-1:0] r_offset_x;
    logic signed [CFG_W-1:0] r_offset_y;

    // front to queue
    logic    push;
    t_cmd    push_cmd;

    // queue to back
    logic    pop;
    t_cmd    head;
    t_q_stat q_stat;

    // back is zeroing the frame store
    logic    clearing;

    // register writes must come only while idle; the block itself does not guard this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= '0;
            r_offset_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OFFSET_X: r_offset_x <= signed'(i_cfg_data);
                CFG_OFFSET_Y: r_offset_y <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // intake: palette load, transparency, clipping, address
    ptb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_offset_x (r_offset_x),
        .i_offset_y (r_offset_y),
        .i_clearing (clearing),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    // decoupling queue so front and back stall on their own
    ptb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (q_stat)
    );

    // framebuffer read-modify-write with forwarding of the last write
    ptb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_res      (o_res)
    );
endmodule
`default_nettype wire

@@ hw/rtl/ptb_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptb_checker - port level checks of the blitter
// Watches reset behavior, result channel and reported addresses.
// ----------------------------------------------------------------------------
module ptb_checker import ptb_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_ready,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic                 i_out_done,
    input wire logic [FB_ADDR_W-1:0] i_out_addr,
    input wire logic [7:0]           i_out_byte
);
    // reset starts the clearing pass and empties the result register
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_in_ready && !i_out_valid))
        else $error("ready or result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_out_done) && $stable(i_out_addr) && $stable(i_out_byte)))
        else $error("stalled result changed");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_done) |-> ((i_out_addr == '0) && (i_out_byte == 8'h00)))
        else $error("result without write carries address or data");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_done) |-> (i_out_addr < FB_ADDR_W'(STORE_BYTES)))
        else $error("write address beyond frame store");
endmodule

bind palette_threshold_1bpp_blitter ptb_checker u_ptb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_done  (o_res.write_done),
    .i_out_addr  (o_res.fb_address),
    .i_out_byte  (o_res.fb_byte)
);
`default_nettype wire

@@ dv/palette_threshold_1bpp_blitter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_threshold_1bpp_blitter_tb - self-checking bench of the 1 bpp blitter
// Loads thresholded palette entries and draws pixels through the request
// channel, predicts every framebuffer report from a shadow palette and a shadow
// frame store or takes it from a directed row, and compares each result in order.
// ----------------------------------------------------------------------------
module palette_threshold_1bpp_blitter_tb;
    import ptb_pkg::*;

    // one request as offered on the input channel
    typedef struct packed {
        logic       kind;
        logic [7:0] pal_index;
        logic [15:0] pal_color;
        logic [9:0] line_x;
        logic [9:0] line_y;
        logic [9:0] pix_offset;
        logic [7:0] pix_value;
        logic [7:0] trans_index;
        logic [7:0] back_index;
        logic       use_trans;
        logic       restore_bg;
    } t_blit_req;

    // one framebuffer report as seen on the result channel
    typedef struct packed {
        logic        wr;
        logic [16:0] addr;
        logic [7:0]  data;
    } t_blit_res;

    typedef struct packed {
        t_blit_req req;
        logic      typed;
        t_blit_res res;
    } t_blit_row;

    localparam t_blit_res NO_WRITE    = '0;
    localparam int        STALL_LIMIT = 400000;  // covers the frame clearing pass
    localparam int        HOLD_CYCLES = 300;
    localparam int        N_PHASES    = 7;

    // offset settings walked by the random part, extremes among them
    localparam int PH_OX   [N_PHASES] = '{0, -1024, 1023, -1024, 0, 1023, 0};
    localparam int PH_OY   [N_PHASES] = '{0, -768, 767, 767, 0, -768, 0};
    localparam int PH_RND  [N_PHASES] = '{0, 0, 0, 0, 1, 0, 1};
    localparam int PH_LEN  [N_PHASES] = '{500, 40, 40, 60, 360, 40, 400};
    localparam int PH_CALM [N_PHASES] = '{0, 0, 0, 0, 1, 0, 0};

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ptb_in_if  req_if ();
    ptb_out_if res_if ();

    palette_threshold_1bpp_blitter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow state of the block
    logic      pal_bit  [PALETTE_SIZE];
    logic [7:0] fb_mirror [STORE_BYTES];
    int        off_x;
    int        off_y;

    t_blit_res fb_reports_due [$];
    t_blit_row directed_rows  [$];

    int  mismatch_count;
    int  results_checked;
    int  palette_loads;
    int  pixel_draws;
    int  byte_writes;
    int  settings_used;
    bit  calm;          // no idling on either side
    bit  hold_armed;    // main asks for one long receiver hold-off
    bit  hold_done;

    // ------------------------------------------------------------------------
    // predictor: updates the shadow palette / frame store, returns the report
    // ------------------------------------------------------------------------
    function automatic t_blit_res blit_predict(input t_blit_req r);
        t_blit_res  res;
        int         gray;
        int         x;
        int         y;
        int         addr;
        logic [7:0] idx;
        logic [7:0] mask;
        res = NO_WRITE;
        if (r.kind == REQ_PALETTE) begin
            gray = ((int'(r.pal_color) & 'hF800) >> 8) + ((int'(r.pal_color) & 'h07E0) >> 2)
                 + ((int'(r.pal_color) & 'h001F) << 3);
            if (int'(r.pal_index) < PALETTE_SIZE)
                pal_bit[r.pal_index] = (gray >= 512);
            return res;
        end
        if (int'(r.pix_offset) >= FB_WIDTH)
            return res;
        idx = r.pix_value;
        if (r.restore_bg) begin
            if (idx == r.trans_index)
                idx = r.back_index;
        end else if (r.use_trans && idx == r.trans_index) begin
            return res;
        end
        x = int'(r.line_x) + int'(r.pix_offset) + off_x;
        y = int'(r.line_y) + off_y;
        if (x < 0 || x >= VIS_WIDTH || y < 0 || y >= FB_HEIGHT)
            return res;
        addr = x / 8 + y * ROW_BYTES;
        mask = 8'h80 >> (x % 8);
        if (int'(idx) < PALETTE_SIZE && pal_bit[idx])
            fb_mirror[addr] = fb_mirror[addr] | mask;
        else
            fb_mirror[addr] = fb_mirror[addr] & ~mask;
        res.wr   = 1'b1;
        res.addr = 17'(addr);
        res.data = fb_mirror[addr];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------------
    function automatic t_blit_req pal_req(input int i, input int c);
        t_blit_req r;
        r           = '0;
        r.kind      = REQ_PALETTE;
        r.pal_index = 8'(i);
        r.pal_color = 16'(c);
        return r;
    endfunction

    function automatic t_blit_req pix_req(input int lx, input int ly, input int poff,
                                          input int pv, input int ti, input int bi,
                                          input bit ut, input bit rb);
        t_blit_req r;
        r             = '0;
        r.kind        = REQ_PIXEL;
        r.line_x      = 10'(lx);
        r.line_y      = 10'(ly);
        r.pix_offset  = 10'(poff);
        r.pix_value   = 8'(pv);
        r.trans_index = 8'(ti);
        r.back_index  = 8'(bi);
        r.use_trans   = ut;
        r.restore_bg  = rb;
        return r;
    endfunction

    function automatic t_blit_res wrote(input int a, input int b);
        t_blit_res res;
        res.wr   = 1'b1;
        res.addr = 17'(a);
        res.data = 8'(b);
        return res;
    endfunction

    function automatic t_blit_req random_req();
        t_blit_req r;
        r.kind        = 1'($urandom);
        r.pal_index   = 8'($urandom);
        r.pal_color   = 16'($urandom);
        r.line_x      = 10'($urandom);
        r.line_y      = 10'($urandom_range(0, FB_HEIGHT - 1));
        r.pix_offset  = 10'($urandom);
        r.pix_value   = 8'($urandom);
        r.trans_index = 8'($urandom);
        r.back_index  = 8'($urandom);
        r.use_trans   = 1'($urandom);
        r.restore_bg  = 1'($urandom);
        return r;
    endfunction

    // random colors half the time, else right at the gray threshold or the extremes
    function automatic logic [15:0] pick_color();
        case ($urandom_range(7))
            0: return 16'hFC00;    // gray 504, just below
            1: return 16'hFC20;    // gray 512, just at
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // mismatch reporting and result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_report(input t_blit_res got);
        t_blit_res want;
        if (fb_reports_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending (wr %0b addr %0d byte %02h)",
                                      got.wr, got.addr, got.data));
            return;
        end
        want = fb_reports_due.pop_front();
        results_checked++;
        if (got.wr !== want.wr)
            report_mismatch($sformatf("result %0d write_done %0b, want %0b",
                                      results_checked, got.wr, want.wr));
        if (got.addr !== want.addr)
            report_mismatch($sformatf("result %0d fb_address %0d, want %0d",
                                      results_checked, got.addr, want.addr));
        if (got.data !== want.data)
            report_mismatch($sformatf("result %0d fb_byte %02h, want %02h",
                                      results_checked, got.data, want.data));
    endtask

    // ------------------------------------------------------------------------
    // sender side; every task starts and ends just after a rising edge
    // ------------------------------------------------------------------------
    task automatic present_req(input t_blit_req r, input bit typed, input t_blit_res typed_res);
        t_blit_res want;
        // idle cycle by cycle, about 27 of a hundred
        while (!calm && $urandom_range(99) < 27) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.req_type           <= r.kind;
        req_if.palette_index      <= r.pal_index;
        req_if.palette_color      <= r.pal_color;
        req_if.line_x             <= r.line_x;
        req_if.line_y             <= r.line_y;
        req_if.pixel_offset       <= r.pix_offset;
        req_if.pixel_value        <= r.pix_value;
        req_if.transparent_index  <= r.trans_index;
        req_if.background_index   <= r.back_index;
        req_if.uses_transparency  <= r.use_trans;
        req_if.restore_background <= r.restore_bg;
        req_if.valid              <= 1'b1;
        // wait for the transfer
        do @(posedge i_clk); while (!req_if.ready);
        want = blit_predict(r);
        if (typed)
            want = typed_res;
        fb_reports_due.push_back(want);
        if (r.kind == REQ_PALETTE)
            palette_loads++;
        else
            pixel_draws++;
        if (want.wr)
            byte_writes++;
    endtask

    // sender pause until every pending report is back, then the pipe latency
    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (fb_reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);    // wait out the pipeline registers with margin
    endtask

    task automatic write_offsets(input int ox, input int oy);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OFFSET_X;
        i_cfg_data <= CFG_W'(ox);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OFFSET_Y;
        i_cfg_data <= CFG_W'(oy);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        off_x = ox;
        off_y = oy;
        settings_used++;
    endtask

    // random traffic: mostly decoder-like line segments, some palette
    // touch-ups and some free-form pixels
    task automatic run_phase(input int n_items);
        int        left;
        int        pick;
        int        run_len;
        int        s;
        int        ly;
        int        p0;
        t_blit_req r;
        t_blit_req seg;
        left = n_items;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                run_len = $urandom_range(1, 4);
                for (int k = 0; k < run_len && left > 0; k++) begin
                    r           = random_req();
                    r.kind      = REQ_PALETTE;
                    r.pal_color = pick_color();
                    present_req(r, 1'b0, NO_WRITE);
                    left--;
                end
            end else if (pick < 70) begin
                // aim the segment start at the panel (or just past its edge)
                s  = $urandom_range(0, VIS_WIDTH + 7) - 4 - off_x;
                ly = $urandom_range(0, FB_HEIGHT + 3) - 2 - off_y;
                if (s < 0 || s > 2046)
                    s = $urandom_range(0, 2046);
                if (ly < 0 || ly >= FB_HEIGHT)
                    ly = $urandom_range(0, FB_HEIGHT - 1);
                p0 = $urandom_range((s > 1023) ? s - 1023 : 0, (s < 1023) ? s : 1023);
                seg            = random_req();
                seg.kind       = REQ_PIXEL;
                seg.line_x     = 10'(s - p0);
                seg.line_y     = 10'(ly);
                run_len        = $urandom_range(1, 24);
                for (int k = 0; k < run_len && left > 0 && p0 + k <= 1023; k++) begin
                    r            = seg;
                    r.pix_offset = 10'(p0 + k);
                    r.pix_value  = ($urandom_range(3) == 0) ? seg.trans_index : 8'($urandom);
                    r.pal_index  = 8'($urandom);
                    r.pal_color  = 16'($urandom);
                    present_req(r, 1'b0, NO_WRITE);
                    left--;
                end
            end else begin
                r      = random_req();
                r.kind = REQ_PIXEL;
                present_req(r, 1'b0, NO_WRITE);
                left--;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random ready, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left    = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready)
                check_report({res_if.write_done, res_if.fb_address, res_if.fb_byte});
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (calm) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= 27);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles without any transfer on either channel
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int stale;
        stale = 0;
        while (stale < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                stale = 0;
            else
                stale++;
        end
        $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        logic [7:0] order [PALETTE_SIZE];
        logic [7:0] swap;
        int         j;
        t_blit_row  row;

        mismatch_count  = 0;
        results_checked = 0;
        palette_loads   = 0;
        pixel_draws     = 0;
        byte_writes     = 0;
        settings_used   = 0;
        calm            = 1'b0;
        hold_armed      = 1'b0;
        hold_done       = 1'b0;
        off_x           = 0;
        off_y           = 0;
        foreach (pal_bit[q])
            pal_bit[q] = 1'b0;
        foreach (fb_mirror[q])
            fb_mirror[q] = 8'h00;

        i_rst_n                   <= 1'b0;
        i_cfg_we                  <= 1'b0;
        i_cfg_idx                 <= CFG_OFFSET_X;
        i_cfg_data                <= '0;
        req_if.valid              <= 1'b0;
        req_if.req_type           <= REQ_PALETTE;
        req_if.palette_index      <= '0;
        req_if.palette_color      <= '0;
        req_if.line_x             <= '0;
        req_if.line_y             <= '0;
        req_if.pixel_offset       <= '0;
        req_if.pixel_value        <= '0;
        req_if.transparent_index  <= '0;
        req_if.background_index   <= '0;
        req_if.uses_transparency  <= 1'b0;
        req_if.restore_background <= 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // block clears its frame store now; input ready stays low meanwhile
        write_offsets(0, 0);

        // directed rows, zero offsets; palette entries loaded before use
        directed_rows.push_back('{pal_req(0, 'h0000), 1'b1, NO_WRITE});
        directed_rows.push_back('{pal_req(255, 'hFFFF), 1'b1, NO_WRITE});
        directed_rows.push_back('{pal_req(1, 'hFC00), 1'b1, NO_WRITE});   // gray 504 -> 0
        directed_rows.push_back('{pal_req(2, 'hFC20), 1'b1, NO_WRITE});   // gray 512 -> 1
        directed_rows.push_back('{pal_req(4, 'h07E0), 1'b1, NO_WRITE});   // green only
        // set, set the other end, then clear the leftmost pixel of byte 0
        directed_rows.push_back('{pix_req(0, 0, 0, 255, 0, 0, 0, 0), 1'b1, wrote(0, 'h80)});
        directed_rows.push_back('{pix_req(0, 0, 7, 255, 0, 0, 0, 0), 1'b1, wrote(0, 'h81)});
        directed_rows.push_back('{pix_req(0, 0, 0, 0, 1, 1, 0, 0), 1'b1, wrote(0, 'h01)});
        // last byte of the panel
        directed_rows.push_back('{pix_req(1023, 767, 0, 2, 0, 0, 0, 0), 1'b1,
                                  wrote(STORE_BYTES - 1, 'h01)});
        // off the right edge, then every position field at its maximum
        directed_rows.push_back('{pix_req(1023, 0, 1, 255, 0, 0, 0, 0), 1'b1, NO_WRITE});
        directed_rows.push_back('{pix_req(1023, 767, 1023, 255, 0, 0, 0, 0), 1'b1, NO_WRITE});
        // transparent skip
        directed_rows.push_back('{pix_req(8, 0, 0, 255, 255, 2, 1, 0), 1'b1, NO_WRITE});
        // background restore wins over transparency
        directed_rows.push_back('{pix_req(8, 0, 0, 255, 255, 2, 1, 1), 1'b1, wrote(1, 'h80)});
        directed_rows.push_back('{pix_req(9, 0, 0, 255, 255, 0, 0, 1), 1'b1, wrote(1, 'h80)});
        // non-matching index passes through both modes
        directed_rows.push_back('{pix_req(10, 0, 0, 255, 0, 4, 1, 0), 1'b0, NO_WRITE});
        directed_rows.push_back('{pix_req(11, 0, 0, 1, 255, 255, 0, 1), 1'b0, NO_WRITE});
        directed_rows.push_back('{pix_req(0, 1, 1023, 255, 0, 0, 0, 0), 1'b1, wrote(255, 'h01)});
        directed_rows.push_back('{pix_req(0, 767, 0, 2, 0, 0, 0, 0), 1'b1,
                                  wrote(767 * ROW_BYTES, 'h80)});
        foreach (directed_rows[q]) begin
            row = directed_rows[q];
            present_req(row.req, row.typed, row.res);
        end
        drain_results();

        // full palette in shuffled order, so any index is defined from here on
        foreach (order[q])
            order[q] = 8'(q);
        for (int q = PALETTE_SIZE - 1; q > 0; q--) begin
            j        = $urandom_range(q);
            swap     = order[q];
            order[q] = order[j];
            order[j] = swap;
        end
        for (int q = 0; q < PALETTE_SIZE; q++)
            present_req(pal_req(order[q], pick_color()), 1'b0, NO_WRITE);

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            if (PH_RND[p] != 0)
                write_offsets($urandom_range(0, 2047) - 1024, $urandom_range(0, 1535) - 768);
            else
                write_offsets(PH_OX[p], PH_OY[p]);
            calm = (PH_CALM[p] != 0);
            // receiver holds off while the sender keeps offering
            if (PH_CALM[p] != 0)
                hold_armed = 1'b1;
            run_phase(PH_LEN[p]);
        end
        calm = 1'b0;
        drain_results();

        $display("covered %0d palette loads and %0d pixel draws, %0d reports checked",
                 palette_loads, pixel_draws, results_checked);
        $display("%0d byte writes over %0d offset settings, one %0d-cycle result stall",
                 byte_writes, settings_used, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ptb_pkg.sv
hw/rtl/ptb_in_if.sv
hw/rtl/ptb_out_if.sv
hw/rtl/ptb_ram.sv
hw/rtl/ptb_front.sv
hw/rtl/ptb_queue.sv
hw/rtl/ptb_back.sv
hw/rtl/palette_threshold_1bpp_blitter.sv
hw/rtl/ptb_checker.sv
dv/palette_threshold_1bpp_blitter_tb.sv
